[hw/rtl/wtvm_pkg.sv]
// ----------------------------------------------------------------------------
// wtvm_pkg
// Shared widths, register indexes and state type of the sliding-window VWAP
// and momentum block.
// ----------------------------------------------------------------------------
package wtvm_pkg;

  // Field widths of one trade and one result
  localparam int PRICE_W = 32;
  localparam int QTY_W   = 24;
  localparam int FILL_W  = 7;
  localparam int VWAP_W  = 32;
  localparam int MOM_W   = 33;

  // Running sums: at most 2^FILL_W - 1 trades ever sit in the window
  localparam int PROD_W     = PRICE_W + QTY_W;
  localparam int NOTIONAL_W = PROD_W + FILL_W;
  localparam int VOL_W      = QTY_W + FILL_W;

  // Serial units: two quantity bits per multiply step, one quotient bit per divide step
  localparam int MUL_STEPS = QTY_W / 2;
  localparam int DIV_STEPS = VWAP_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  // Ring depth default
  localparam int unsigned MAX_WINDOW_DEF = 64;

  // Configuration port
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;
  localparam logic CFG_IDX_WINDOW_LEN = 1'b0;
  localparam logic [FILL_W-1:0] WINDOW_LEN_RESET = 7'd10;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_MUL,
    ST_ADD,
    ST_SUB,
    ST_DIV,
    ST_DONE
  } wtvm_state_e;

endpackage

[hw/rtl/wtvm_trade_if.sv]
// ----------------------------------------------------------------------------
// wtvm_trade_if
// Valid/ready channel carrying one trade (price and quantity).
// ----------------------------------------------------------------------------
interface wtvm_trade_if;
  import wtvm_pkg::*;

  logic               valid;
  logic               ready;
  logic [PRICE_W-1:0] trade_price;
  logic [QTY_W-1:0]   trade_qty;

  modport source (output valid, output trade_price, output trade_qty, input ready);
  modport sink   (input valid, input trade_price, input trade_qty, output ready);

endinterface

[hw/rtl/wtvm_result_if.sv]
// ----------------------------------------------------------------------------
// wtvm_result_if
// Valid/ready channel carrying one result (VWAP, momentum, fill, flag).
// ----------------------------------------------------------------------------
interface wtvm_result_if;
  import wtvm_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [VWAP_W-1:0]        vwap;
  logic signed [MOM_W-1:0]  momentum;
  logic [FILL_W-1:0]        window_fill;
  logic                     zero_volume;

  modport source (output valid, output vwap, output momentum, output window_fill,
                  output zero_volume, input ready);
  modport sink   (input valid, input vwap, input momentum, input window_fill,
                  input zero_volume, output ready);

endinterface

[hw/rtl/windowed_trade_vwap_momentum.sv]
// ----------------------------------------------------------------------------
// windowed_trade_vwap_momentum
// Sliding-window VWAP and momentum over a ring of recent trades.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake             contents
//  trade_i   in   valid/ready           trade_price, trade_qty
//  result_o  out  valid/ready           vwap, momentum, window_fill, zero_volume
//  apb       in   psel/penable/pwrite   window_len at byte address 0
//
//  An item goes from acceptance to its result through one ring read, 12
//  radix-4 multiply steps (new and evicted product side by side), two sum
//  updates and 32 restoring divide steps; the divide steps are skipped when
//  window volume is zero. The next item is accepted once the previous one
//  has left the datapath; a result waits in the output register and only a
//  result still held there stalls the following one. Reset and a window_len
//  write empty the window; the ring itself is never cleared.
//
module windowed_trade_vwap_momentum #(
  parameter int unsigned MaxWindow = wtvm_pkg::MAX_WINDOW_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  wtvm_trade_if.sink                          trade_i,
  wtvm_result_if.source                       result_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [wtvm_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [wtvm_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [wtvm_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready
);
  import wtvm_pkg::*;

  localparam int PtrW = $clog2(MaxWindow);
  localparam int AW   = ((PtrW > FILL_W) ? PtrW : FILL_W) + 2;

  // ---------------------------------------------------------------------------
  // Declarations
  // ---------------------------------------------------------------------------
  wtvm_state_e state_q, state_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [FILL_W-1:0]     window_len_q;
  logic [PtrW-1:0]       wp_q;
  logic [FILL_W-1:0]     fill_q;
  logic [NOTIONAL_W-1:0] notional_q, notional_d;
  logic [VOL_W-1:0]      volume_q, volume_d;
  logic                  out_valid_q;

  // ring
  logic [PRICE_W-1:0] price_mem [MaxWindow];
  logic [QTY_W-1:0]   qty_mem   [MaxWindow];
  logic [PtrW-1:0]    rd_addr;
  logic [PRICE_W-1:0] rd_price_q;
  logic [QTY_W-1:0]   rd_qty_q;

  // per-item payload
  logic [PRICE_W-1:0] price_q;
  logic [QTY_W-1:0]   qty_q;
  logic               evict_q;
  logic               single_q;
  logic [PRICE_W-1:0] oldest_q;

  // serial multipliers: new trade and evicted trade
  logic [PRICE_W-1:0] mp_n_q, mp_o_q;
  logic [PRICE_W-1:0] mh_n_q, mh_o_q;
  logic [QTY_W-1:0]   mq_n_q, mq_o_q;
  logic [PRICE_W+1:0] msum_n, msum_o;

  // serial divider
  logic [VOL_W-1:0]   rem_q;
  logic [VWAP_W-1:0]  dsr_q;
  logic [VOL_W:0]     div_t;
  logic               div_ge;

  // output register
  logic [VWAP_W-1:0]       vwap_q;
  logic signed [MOM_W-1:0] mom_q;
  logic [FILL_W-1:0]       ofill_q;
  logic                    ozero_q;

  // control
  logic               in_fire, cfg_we, out_load, mem_we, zero_vol;
  logic [FILL_W-1:0]  eff_len;
  logic [AW-1:0]      back_diff, back_wrap;
  logic [PtrW-1:0]    old_addr, old_next, wp_next;

  // ---------------------------------------------------------------------------
  // Helpers
  // ---------------------------------------------------------------------------
  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    logic [PtrW-1:0] r;
    if (p == PtrW'(MaxWindow - 1)) r = '0;
    else r = p + 1'b1;
    return r;
  endfunction

  // One radix-4 multiply step: add digit times price to the high half
  function automatic logic [PRICE_W+1:0] mul_step(input logic [PRICE_W-1:0] hi,
                                                  input logic [PRICE_W-1:0] p,
                                                  input logic [1:0] d);
    logic [PRICE_W+1:0] m;
    case (d)
      2'd1:    m = {2'b00, p};
      2'd2:    m = {1'b0, p, 1'b0};
      2'd3:    m = {2'b00, p} + {1'b0, p, 1'b0};
      default: m = '0;
    endcase
    return {2'b00, hi} + m;
  endfunction

  // ---------------------------------------------------------------------------
  // Configuration port
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite & (paddr[2] == CFG_IDX_WINDOW_LEN);
  assign prdata = (paddr[2] == CFG_IDX_WINDOW_LEN) ?
                  APB_DATA_W'(window_len_q) : '0;

  // Effective window length: zero acts as one, clamp to ring depth
  always_comb begin
    if (window_len_q == '0) eff_len = FILL_W'(1);
    else if (int'(window_len_q) > int'(MaxWindow)) eff_len = FILL_W'(MaxWindow);
    else eff_len = window_len_q;
  end

  // ---------------------------------------------------------------------------
  // Ring addressing: slot fill_q entries behind the write pointer
  // ---------------------------------------------------------------------------
  always_comb begin
    back_diff = AW'(wp_q) - AW'(fill_q);
    back_wrap = back_diff[AW-1] ? back_diff + AW'(MaxWindow) : back_diff;
    old_addr  = back_wrap[PtrW-1:0];
    old_next  = ptr_inc(old_addr);
    wp_next   = ptr_inc(wp_q);
  end

  // ---------------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------------
  assign zero_vol = (volume_q == '0);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_fire) state_d = ST_LOAD;
      ST_LOAD: state_d = ST_MUL;
      ST_MUL:  if (cnt_q == CNT_W'(MUL_STEPS - 1)) state_d = ST_ADD;
      ST_ADD:  state_d = ST_SUB;
      ST_SUB:  state_d = zero_vol ? ST_DONE : ST_DIV;
      ST_DIV:  if (cnt_q == CNT_W'(DIV_STEPS - 1)) state_d = ST_DONE;
      ST_DONE: if (!out_valid_q || result_o.ready) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Control outputs
  // ---------------------------------------------------------------------------
  always_comb begin
    trade_i.ready = 1'b0;
    mem_we        = 1'b0;
    out_load      = 1'b0;
    rd_addr       = old_addr;
    cnt_d         = '0;
    unique case (state_q)
      ST_IDLE: trade_i.ready = 1'b1;
      ST_LOAD: begin
        mem_we  = 1'b1;
        rd_addr = old_next;
      end
      ST_MUL:  cnt_d = cnt_q + 1'b1;
      ST_DIV:  cnt_d = cnt_q + 1'b1;
      ST_DONE: out_load = !out_valid_q || result_o.ready;
      default: ;
    endcase
  end

  assign in_fire = trade_i.valid & trade_i.ready;

  // ---------------------------------------------------------------------------
  // Sum updates
  // ---------------------------------------------------------------------------
  always_comb begin
    volume_d   = volume_q;
    notional_d = notional_q;
    case (state_q)
      ST_LOAD: volume_d = volume_q + VOL_W'(qty_q) - (evict_q ? VOL_W'(rd_qty_q) : '0);
      ST_ADD:  notional_d = notional_q + NOTIONAL_W'({mh_n_q, mq_n_q});
      ST_SUB:  notional_d = notional_q - NOTIONAL_W'({mh_o_q, mq_o_q});
      default: ;
    endcase
  end

  // Serial datapath terms
  assign msum_n = mul_step(mh_n_q, mp_n_q, mq_n_q[1:0]);
  assign msum_o = mul_step(mh_o_q, mp_o_q, mq_o_q[1:0]);
  assign div_t  = {rem_q, dsr_q[VWAP_W-1]};
  assign div_ge = (div_t >= {1'b0, volume_q});

  // ---------------------------------------------------------------------------
  // Control registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      cnt_q        <= '0;
      window_len_q <= WINDOW_LEN_RESET;
      wp_q         <= '0;
      fill_q       <= '0;
      notional_q   <= '0;
      volume_q     <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (cfg_we) begin
        window_len_q <= pwdata[FILL_W-1:0];
        wp_q         <= '0;
        fill_q       <= '0;
        notional_q   <= '0;
        volume_q     <= '0;
      end else begin
        notional_q <= notional_d;
        volume_q   <= volume_d;
        if (state_q == ST_LOAD) begin
          wp_q <= wp_next;
          if (!evict_q) fill_q <= fill_q + 1'b1;
        end
      end
      if (out_load) out_valid_q <= 1'b1;
      else if (result_o.ready) out_valid_q <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Ring memory, registered read
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      price_mem[wp_q] <= price_q;
      qty_mem[wp_q]   <= qty_q;
    end
    rd_price_q <= price_mem[rd_addr];
    rd_qty_q   <= qty_mem[rd_addr];
  end

  // ---------------------------------------------------------------------------
  // Payload registers: capture, multiply, divide, result
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          price_q  <= trade_i.trade_price;
          qty_q    <= trade_i.trade_qty;
          evict_q  <= (fill_q >= eff_len);
          single_q <= (fill_q >= eff_len) ? (fill_q == FILL_W'(1)) : (fill_q == '0);
        end
      end
      ST_LOAD: begin
        // read data is the slot of the evicted (or, without eviction, oldest) trade
        mp_n_q   <= price_q;
        mq_n_q   <= qty_q;
        mh_n_q   <= '0;
        mp_o_q   <= evict_q ? rd_price_q : '0;
        mq_o_q   <= evict_q ? rd_qty_q : '0;
        mh_o_q   <= '0;
        oldest_q <= rd_price_q;
      end
      ST_MUL: begin
        // the slot after the evicted one arrives in the first step
        if (cnt_q == '0 && evict_q) oldest_q <= rd_price_q;
        mh_n_q <= msum_n[PRICE_W+1:2];
        mq_n_q <= {msum_n[1:0], mq_n_q[QTY_W-1:2]};
        mh_o_q <= msum_o[PRICE_W+1:2];
        mq_o_q <= {msum_o[1:0], mq_o_q[QTY_W-1:2]};
      end
      ST_SUB: begin
        // quotient fits VWAP_W bits, so the high part starts below the divisor
        rem_q <= notional_d[NOTIONAL_W-1:VWAP_W];
        dsr_q <= notional_d[VWAP_W-1:0];
      end
      ST_DIV: begin
        rem_q <= div_ge ? VOL_W'(div_t - {1'b0, volume_q}) : div_t[VOL_W-1:0];
        dsr_q <= {dsr_q[VWAP_W-2:0], div_ge};
      end
      default: ;
    endcase

    if (out_load) begin
      vwap_q  <= zero_vol ? '0 : dsr_q;
      mom_q   <= single_q ? '0 :
                 $signed(MOM_W'({1'b0, price_q}) - MOM_W'({1'b0, oldest_q}));
      ofill_q <= fill_q;
      ozero_q <= zero_vol;
    end
  end

  // ---------------------------------------------------------------------------
  // Result channel
  // ---------------------------------------------------------------------------
  assign result_o.valid       = out_valid_q;
  assign result_o.vwap        = vwap_q;
  assign result_o.momentum    = mom_q;
  assign result_o.window_fill = ofill_q;
  assign result_o.zero_volume = ozero_q;

endmodule

[sim/windowed_trade_vwap_momentum_tb.sv]
// ----------------------------------------------------------------------------
// windowed_trade_vwap_momentum_tb
// Self-checking bench for the sliding-window VWAP and momentum block. A
// scoreboard predictor mirrors the trade ring and the running notional and
// volume sums. It expects one result per accepted trade, and the bench
// compares every result field by field. Directed trades cover field
// extremes, zero volume, window clamping and register decode. Random traffic
// then runs under several window lengths and four handshake idling phases.
// ----------------------------------------------------------------------------
module windowed_trade_vwap_momentum_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import wtvm_pkg::*;

  localparam int unsigned RingDepth    = MAX_WINDOW_DEF;
  localparam int unsigned IdxUnmapped  = 1;
  localparam logic [APB_ADDR_W-1:0] AddrWindowLen =
    APB_ADDR_W'(4 * int'(CFG_IDX_WINDOW_LEN));
  localparam logic [APB_ADDR_W-1:0] AddrUnmapped = APB_ADDR_W'(4 * IdxUnmapped);
  localparam int unsigned ReportLimit  = 10;
  localparam int unsigned SegmentItems = 140;
  // Tail after the last result
  localparam int unsigned TailCycles   = 120;

  typedef struct packed {
    logic [VWAP_W-1:0] vwap;
    logic [MOM_W-1:0]  momentum;
    logic [FILL_W-1:0] fill;
    logic              zero_vol;
  } trade_result_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  wtvm_trade_if  trade_bus ();
  wtvm_result_if result_bus ();

  windowed_trade_vwap_momentum u_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .trade_i  (trade_bus),
    .result_o (result_bus),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // Scoreboard copy of the window
  logic [PRICE_W-1:0] tick_hist [RingDepth];
  logic [QTY_W-1:0]   size_hist [RingDepth];
  int unsigned        head_slot;
  int unsigned        depth_now;
  logic [63:0]        notional_acc;
  logic [31:0]        volume_acc;
  logic [FILL_W-1:0]  win_len_reg;

  trade_result_t vwap_expect_q [$];

  int unsigned mismatch_cnt  = 0;
  int unsigned trades_sent   = 0;
  int unsigned results_seen  = 0;
  int unsigned settings_used = 0;
  int unsigned src_idle_pct  = 0;
  int unsigned snk_stall_pct = 0;

  // 2 ns clock
  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  // Run-time limit
  initial begin
    #2_000_000;
    $display("windowed_trade_vwap_momentum regression: fail");
    $finish;
  end

  // ------------------------------------------------------------------------
  // Prediction
  // ------------------------------------------------------------------------
  function automatic int unsigned ring_slot_back(int unsigned back);
    return (head_slot + RingDepth - back) % RingDepth;
  endfunction

  function automatic int unsigned window_span();
    if (win_len_reg == 0) return 1;
    if (win_len_reg > RingDepth) return RingDepth;
    return int'(win_len_reg);
  endfunction

  function automatic void clear_window(logic [FILL_W-1:0] len);
    win_len_reg  = len;
    head_slot    = 0;
    depth_now    = 0;
    notional_acc = '0;
    volume_acc   = '0;
  endfunction

  function automatic void predict_vwap(logic [PRICE_W-1:0] price, logic [QTY_W-1:0] qty);
    int unsigned   old_slot;
    trade_result_t res;
    // evict the oldest trade once the window is full
    if (depth_now >= window_span()) begin
      old_slot      = ring_slot_back(depth_now);
      notional_acc -= 64'(tick_hist[old_slot]) * 64'(size_hist[old_slot]);
      volume_acc   -= 32'(size_hist[old_slot]);
      depth_now--;
    end
    tick_hist[head_slot] = price;
    size_hist[head_slot] = qty;
    notional_acc += 64'(price) * 64'(qty);
    volume_acc   += 32'(qty);
    head_slot     = (head_slot + 1) % RingDepth;
    depth_now++;
    res.momentum = {1'b0, price} - {1'b0, tick_hist[ring_slot_back(depth_now)]};
    res.zero_vol = (volume_acc == 0);
    res.vwap     = res.zero_vol ? '0 : VWAP_W'(notional_acc / 64'(volume_acc));
    res.fill     = FILL_W'(depth_now);
    vwap_expect_q.push_back(res);
    trades_sent++;
  endfunction

  function automatic void note_mismatch(string what, logic [63:0] exp_v, logic [63:0] act_v);
    mismatch_cnt++;
    if (mismatch_cnt <= ReportLimit)
      $display("[%0t] MISMATCH %s: expected %h, got %h", $realtime, what, exp_v, act_v);
  endfunction

  // ------------------------------------------------------------------------
  // Result monitor: random stalls, field-by-field compare
  // ------------------------------------------------------------------------
  initial begin : result_monitor
    trade_result_t exp_res;
    result_bus.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && result_bus.valid === 1'b1 && result_bus.ready === 1'b1) begin
        results_seen++;
        if (vwap_expect_q.size() == 0) begin
          note_mismatch("result with nothing expected", '0, 64'(result_bus.vwap));
        end else begin
          exp_res = vwap_expect_q.pop_front();
          if (result_bus.vwap !== exp_res.vwap)
            note_mismatch("vwap", 64'(exp_res.vwap), 64'(result_bus.vwap));
          if (result_bus.momentum !== exp_res.momentum)
            note_mismatch("momentum", 64'(exp_res.momentum), 64'(result_bus.momentum));
          if (result_bus.window_fill !== exp_res.fill)
            note_mismatch("window_fill", 64'(exp_res.fill), 64'(result_bus.window_fill));
          if (result_bus.zero_volume !== exp_res.zero_vol)
            note_mismatch("zero_volume", 64'(exp_res.zero_vol), 64'(result_bus.zero_volume));
        end
      end
      result_bus.ready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  // ------------------------------------------------------------------------
  // Drivers
  // ------------------------------------------------------------------------
  // Valid stays high after acceptance so the next item can follow at once
  task automatic send_trade(logic [PRICE_W-1:0] price, logic [QTY_W-1:0] qty);
    while ($urandom_range(99) < src_idle_pct) begin
      trade_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    trade_bus.valid       <= 1'b1;
    trade_bus.trade_price <= price;
    trade_bus.trade_qty   <= qty;
    @(posedge clk_i);
    while (trade_bus.ready !== 1'b1) @(posedge clk_i);
    predict_vwap(price, qty);
  endtask

  // Hold the sender until every expected result is back
  task automatic wait_drain();
    trade_bus.valid <= 1'b0;
    while (vwap_expect_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic apb_write(logic [APB_ADDR_W-1:0] addr, logic [APB_DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (pready !== 1'b1) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (addr == AddrWindowLen) clear_window(data[FILL_W-1:0]);
    @(posedge clk_i);
  endtask

  task automatic apb_read_check(logic [APB_ADDR_W-1:0] addr, logic [APB_DATA_W-1:0] exp_v);
    logic [APB_DATA_W-1:0] got;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (pready !== 1'b1) @(posedge clk_i);
    got = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (got !== exp_v) note_mismatch("window_len readback", 64'(exp_v), 64'(got));
    @(posedge clk_i);
  endtask

  task automatic set_window_len(logic [APB_DATA_W-1:0] data);
    apb_write(AddrWindowLen, data);
    apb_read_check(AddrWindowLen, APB_DATA_W'(data[FILL_W-1:0]));
    settings_used++;
  endtask

  // ------------------------------------------------------------------------
  // Random trade shapes
  // ------------------------------------------------------------------------
  task automatic pick_trade(input logic [PRICE_W-1:0] base,
                            output logic [PRICE_W-1:0] price,
                            output logic [QTY_W-1:0] qty);
    int unsigned shape;
    shape = $urandom_range(99);
    if (shape < 35) begin
      price = $urandom;
      qty   = QTY_W'($urandom);
    end else if (shape < 60) begin
      // quoted market: small moves around a level
      price = base + $urandom_range(2000) - 1000;
      qty   = QTY_W'($urandom_range(5000, 1));
    end else if (shape < 68) begin
      price = $urandom;
      qty   = '0;
    end else if (shape < 76) begin
      price = $urandom_range(1) ? '1 : '0;
      qty   = QTY_W'($urandom);
    end else if (shape < 84) begin
      price = $urandom;
      qty   = '1;
    end else if (shape < 92) begin
      price = $urandom;
      qty   = QTY_W'(1);
    end else begin
      price = base;
      qty   = QTY_W'($urandom_range(3));
    end
  endtask

  // Window lengths visited by the random phases, extremes included
  function automatic logic [APB_DATA_W-1:0] window_plan(int unsigned idx);
    case (idx)
      0:       return 64;
      1:       return 127;
      2:       return 3;
      3:       return 0;
      4:       return 17;
      5:       return 100;
      6:       return 1;
      7:       return 33;
      8:       return 65;
      9:       return 2;
      10:      return 50;
      default: return 10;
    endcase
  endfunction

  // ------------------------------------------------------------------------
  // Tests
  // ------------------------------------------------------------------------
  task automatic test_reset_state();
    apb_read_check(AddrWindowLen, APB_DATA_W'(WINDOW_LEN_RESET));
    // first trade with no volume: flag set, momentum zero
    send_trade(32'h0000_1234, '0);
    send_trade('1, '1);
    send_trade('0, '1);
    wait_drain();
  endtask

  task automatic test_field_extremes();
    set_window_len(2);
    send_trade('1, '1);
    send_trade('0, '1);           // most negative momentum
    send_trade('1, QTY_W'(1));    // most positive momentum
    send_trade('0, '0);
    send_trade('1, '0);           // full window with zero volume
    send_trade(32'h8000_0000, 24'h80_0000);
    wait_drain();
  endtask

  task automatic test_register_decode();
    // unmapped register: no clear, window keeps going
    apb_write(AddrUnmapped, 32'd3);
    send_trade(32'd100, 24'd7);
    send_trade(32'd40, 24'd9);
    wait_drain();
    // only the low bits of the write data count
    set_window_len(32'hFFFF_FF05);
    send_trade(32'd1000, 24'd1);
    send_trade(32'd999, 24'd2);
    send_trade(32'd1003, 24'd3);
    wait_drain();
  endtask

  task automatic test_window_clamps();
    // zero length behaves as one
    set_window_len(0);
    send_trade(32'd500, '0);
    send_trade(32'd600, 24'd3);
    send_trade(32'd7, '1);
    wait_drain();
    // all-ones write clamps to the ring depth
    set_window_len(32'hFFFF_FFFF);
    send_trade(32'd11, 24'd5);
    send_trade(32'd2, 24'd6);
    wait_drain();
    set_window_len(1);
    send_trade(32'hDEAD_BEEF, 24'h5A_A5A5);
    send_trade(32'h2152_4110, 24'hA5_5A5A);
    wait_drain();
  endtask

  task automatic test_random_traffic(int unsigned src_pct, int unsigned snk_pct,
                                     int unsigned phase);
    int unsigned        seg;
    int unsigned        n;
    int unsigned        k;
    int unsigned        burst;
    int unsigned        hold_at;
    logic [PRICE_W-1:0] base;
    logic [PRICE_W-1:0] price;
    logic [QTY_W-1:0]   qty;
    wait_drain();
    src_idle_pct  = src_pct;
    snk_stall_pct = snk_pct;
    for (seg = 0; seg < 3; seg++) begin
      wait_drain();
      set_window_len(window_plan(phase * 3 + seg));
      case ($urandom_range(2))
        0:       base = $urandom_range(5000);
        1:       base = $urandom;
        default: base = 32'hFFFF_FFFF - $urandom_range(5000);
      endcase
      hold_at = $urandom_range(120, 20);
      n = 0;
      while (n < SegmentItems) begin
        if (n == hold_at) wait_drain();
        if ($urandom_range(99) < 3) begin
          // zero-quantity run long enough to empty the window volume
          burst = window_span() + 1;
          for (k = 0; k < burst; k++) send_trade($urandom, '0);
          n += burst;
        end else begin
          pick_trade(base, price, qty);
          send_trade(price, qty);
          n++;
        end
      end
    end
    wait_drain();
  endtask

  // ------------------------------------------------------------------------
  // Sequence
  // ------------------------------------------------------------------------
  initial begin : stimulus
    rst_ni                <= 1'b0;
    trade_bus.valid       <= 1'b0;
    trade_bus.trade_price <= '0;
    trade_bus.trade_qty   <= '0;
    psel                  <= 1'b0;
    penable               <= 1'b0;
    pwrite                <= 1'b0;
    paddr                 <= '0;
    pwdata                <= '0;
    clear_window(WINDOW_LEN_RESET);
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_state();
    test_field_extremes();
    test_register_decode();
    test_window_clamps();
    test_random_traffic(0, 0, 0);
    test_random_traffic(51, 0, 1);
    test_random_traffic(0, 51, 2);
    test_random_traffic(26, 26, 3);

    wait_drain();
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    repeat (TailCycles) @(posedge clk_i);

    $display("Ran %0d trades through %0d window_len settings and four idling phases;",
             trades_sent, settings_used);
    $display("checked %0d results, %0d mismatches, %0d still outstanding.",
             results_seen, mismatch_cnt, vwap_expect_q.size());
    if (mismatch_cnt == 0 && vwap_expect_q.size() == 0) begin
      $display("windowed_trade_vwap_momentum regression: pass");
    end else begin
      $display("windowed_trade_vwap_momentum regression: fail");
    end
    $finish;
  end

endmodule
